/* hw/rtl/rsb_pkg.sv */
// shared types and constants for the rgb to spectrum basis blend
package rsb_pkg;

    localparam int unsigned VALUE_W = 16;
    localparam int unsigned PROD_W = 2 * VALUE_W;
    // three products of 16 x 16 bits
    localparam int unsigned ACC_W = PROD_W + 2;
    localparam int unsigned FRAC_SHIFT = 15;
    localparam int unsigned BASIS_COUNT = 7;

    localparam logic [ACC_W:0] ROUND_BIAS = (ACC_W + 1)'(1) << (FRAC_SHIFT - 1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    localparam logic [2:0] BASIS_WHITE = 3'd0;
    localparam logic [2:0] BASIS_CYAN = 3'd1;
    localparam logic [2:0] BASIS_MAGENTA = 3'd2;
    localparam logic [2:0] BASIS_YELLOW = 3'd3;
    localparam logic [2:0] BASIS_RED = 3'd4;
    localparam logic [2:0] BASIS_GREEN = 3'd5;
    localparam logic [2:0] BASIS_BLUE = 3'd6;

    typedef struct packed {
        logic               operation;
        logic [2:0]         basis_select;
        logic [1:0]         sample_slot;
        logic [VALUE_W-1:0] entry_value;
        logic [VALUE_W-1:0] red;
        logic [VALUE_W-1:0] green;
        logic [VALUE_W-1:0] blue;
    } item_t;

    typedef struct packed {
        logic [1:0]         out_slot;
        logic [VALUE_W-1:0] spectrum_value;
        logic               last_sample;
    } result_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SORT,
        SEQ_ISSUE,
        SEQ_WAIT
    } seq_state_t;

    typedef enum logic [1:0] {
        TERM_WHITE,
        TERM_SECONDARY,
        TERM_PRIMARY
    } term_t;

    // sequencer to multiply-accumulate unit
    typedef struct packed {
        logic               issue;
        logic               first;
        logic               last;
        logic               take;
        logic [VALUE_W-1:0] weight;
    } mac_ctl_t;

    // multiply-accumulate unit back to sequencer
    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] value;
    } mac_stat_t;

endpackage

/* hw/rtl/rsb_if.sv */
// valid/ready channels for requests and results
interface rsb_item_if;
    logic           valid;
    logic           ready;
    rsb_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rsb_result_if;
    logic             valid;
    logic             ready;
    rsb_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/rsb_table.sv */
// basis spectrum memory, one write and one registered read port
module rsb_table #(
    parameter int unsigned DEPTH = 28,
    parameter int unsigned ADDR_W = 5
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [rsb_pkg::VALUE_W-1:0]  wr_data,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [rsb_pkg::VALUE_W-1:0]  rd_data
);

    logic [rsb_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [rsb_pkg::VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/rsb_mac.sv */
// shared multiply-accumulate unit with rounding and saturation
module rsb_mac (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rsb_pkg::mac_ctl_t            ctl,
    input  logic [rsb_pkg::VALUE_W-1:0]  rd_data,
    output rsb_pkg::mac_stat_t           stat
);

    logic                                s1_valid_reg, s1_valid_next;
    logic                                s1_first_reg, s1_first_next;
    logic                                s1_last_reg, s1_last_next;
    logic [rsb_pkg::VALUE_W-1:0]         s1_weight_reg, s1_weight_next;
    logic                                p_valid_reg, p_valid_next;
    logic                                p_first_reg, p_first_next;
    logic                                p_last_reg, p_last_next;
    logic [rsb_pkg::PROD_W-1:0]          p_reg, p_next;
    logic [rsb_pkg::ACC_W-1:0]           acc_reg, acc_next;
    logic                                done_reg, done_next;
    logic [rsb_pkg::ACC_W:0]             rounded;
    logic [rsb_pkg::ACC_W-rsb_pkg::FRAC_SHIFT:0] shifted;

    always_comb
    begin
        s1_valid_next  = ctl.issue;
        s1_first_next  = ctl.first;
        s1_last_next   = ctl.last;
        s1_weight_next = ctl.weight;
        // table data arrives together with stage one
        p_valid_next   = s1_valid_reg;
        p_first_next   = s1_first_reg;
        p_last_next    = s1_last_reg;
        p_next         = rsb_pkg::PROD_W'(s1_weight_reg) * rsb_pkg::PROD_W'(rd_data);
        acc_next       = acc_reg;
        if (p_valid_reg)
        begin
            acc_next = (p_first_reg ? '0 : acc_reg) + rsb_pkg::ACC_W'(p_reg);
        end
        done_next = done_reg;
        if (ctl.take)
        begin
            done_next = 1'b0;
        end
        else if (p_valid_reg && p_last_reg)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            p_valid_reg  <= p_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg  <= s1_first_next;
        s1_last_reg   <= s1_last_next;
        s1_weight_reg <= s1_weight_next;
        p_first_reg   <= p_first_next;
        p_last_reg    <= p_last_next;
        p_reg         <= p_next;
        acc_reg       <= acc_next;
    end

    // round to q4.12 and clamp
    assign rounded = {1'b0, acc_reg} + rsb_pkg::ROUND_BIAS;
    assign shifted = rounded[rsb_pkg::ACC_W:rsb_pkg::FRAC_SHIFT];

    always_comb
    begin
        stat.done = done_reg;
        if (|shifted[rsb_pkg::ACC_W-rsb_pkg::FRAC_SHIFT:rsb_pkg::VALUE_W])
        begin
            stat.value = '1;
        end
        else
        begin
            stat.value = shifted[rsb_pkg::VALUE_W-1:0];
        end
    end

endmodule

/* hw/rtl/rsb_seq.sv */
// sequencer: channel sort, table reads, term issue and result register
module rsb_seq #(
    parameter int unsigned SAMPLES = 4,
    parameter int unsigned ADDR_W = 5,
    parameter int unsigned SLOT_W = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    rsb_item_if.sink                     item,
    rsb_result_if.source                 result,
    output logic                         wr_en,
    output logic [ADDR_W-1:0]            wr_addr,
    output logic                         rd_en,
    output logic [ADDR_W-1:0]            rd_addr,
    output rsb_pkg::mac_ctl_t            ctl,
    input  rsb_pkg::mac_stat_t           stat
);

    rsb_pkg::seq_state_t          state_reg, state_next;
    rsb_pkg::term_t               term_reg, term_next;
    logic [SLOT_W-1:0]            sample_reg, sample_next;
    logic [rsb_pkg::VALUE_W-1:0]  red_reg, red_next;
    logic [rsb_pkg::VALUE_W-1:0]  green_reg, green_next;
    logic [rsb_pkg::VALUE_W-1:0]  blue_reg, blue_next;
    logic [rsb_pkg::VALUE_W-1:0]  w_min_reg, w_min_next;
    logic [rsb_pkg::VALUE_W-1:0]  w_mid_reg, w_mid_next;
    logic [rsb_pkg::VALUE_W-1:0]  w_top_reg, w_top_next;
    logic [2:0]                   sec_reg, sec_next;
    logic [2:0]                   pri_reg, pri_next;
    logic                         res_valid_reg, res_valid_next;
    rsb_pkg::result_t             res_data_reg, res_data_next;

    logic                         accept;
    logic                         out_free;
    logic                         emit;
    logic                         last_sample;
    logic [2:0]                   rd_basis;

    assign accept      = item.valid && item.ready;
    assign out_free    = !res_valid_reg || result.ready;
    assign emit        = (state_reg == rsb_pkg::SEQ_WAIT) && stat.done && out_free;
    assign last_sample = (sample_reg == SLOT_W'(SAMPLES - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rsb_pkg::SEQ_IDLE:
            begin
                if (accept && item.data.operation == rsb_pkg::OP_CONVERT)
                begin
                    state_next = rsb_pkg::SEQ_SORT;
                end
            end
            rsb_pkg::SEQ_SORT:
            begin
                state_next = rsb_pkg::SEQ_ISSUE;
            end
            rsb_pkg::SEQ_ISSUE:
            begin
                if (term_reg == rsb_pkg::TERM_PRIMARY)
                begin
                    state_next = rsb_pkg::SEQ_WAIT;
                end
            end
            rsb_pkg::SEQ_WAIT:
            begin
                if (emit)
                begin
                    state_next = last_sample ? rsb_pkg::SEQ_IDLE : rsb_pkg::SEQ_ISSUE;
                end
            end
            default:
            begin
                state_next = rsb_pkg::SEQ_IDLE;
            end
        endcase
    end

    // outputs toward table, mac unit, request channel and result channel
    always_comb
    begin
        item.ready = (state_reg == rsb_pkg::SEQ_IDLE);
        wr_en      = accept && item.data.operation == rsb_pkg::OP_LOAD
                     && item.data.basis_select < 3'(rsb_pkg::BASIS_COUNT)
                     && int'(item.data.sample_slot) < SAMPLES;
        wr_addr    = ADDR_W'(int'(item.data.basis_select) * SAMPLES
                     + int'(item.data.sample_slot));
        case (term_reg)
            rsb_pkg::TERM_WHITE:
            begin
                rd_basis   = rsb_pkg::BASIS_WHITE;
                ctl.weight = w_min_reg;
            end
            rsb_pkg::TERM_SECONDARY:
            begin
                rd_basis   = sec_reg;
                ctl.weight = w_mid_reg;
            end
            default:
            begin
                rd_basis   = pri_reg;
                ctl.weight = w_top_reg;
            end
        endcase
        rd_en     = (state_reg == rsb_pkg::SEQ_ISSUE);
        rd_addr   = ADDR_W'(int'(rd_basis) * SAMPLES + int'(sample_reg));
        ctl.issue = (state_reg == rsb_pkg::SEQ_ISSUE);
        ctl.first = (term_reg == rsb_pkg::TERM_WHITE);
        ctl.last  = (term_reg == rsb_pkg::TERM_PRIMARY);
        ctl.take  = emit;
        result.valid = res_valid_reg;
        result.data  = res_data_reg;
    end

    // datapath registers
    always_comb
    begin
        term_next      = term_reg;
        sample_next    = sample_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        w_min_next     = w_min_reg;
        w_mid_next     = w_mid_reg;
        w_top_next     = w_top_reg;
        sec_next       = sec_reg;
        pri_next       = pri_reg;
        res_valid_next = res_valid_reg && !result.ready;
        res_data_next  = res_data_reg;

        if (accept)
        begin
            red_next    = item.data.red;
            green_next  = item.data.green;
            blue_next   = item.data.blue;
            term_next   = rsb_pkg::TERM_WHITE;
            sample_next = '0;
        end

        if (state_reg == rsb_pkg::SEQ_SORT)
        begin
            // smallest channel picks the secondary, ties to red then green
            if (red_reg <= green_reg && red_reg <= blue_reg)
            begin
                w_min_next = red_reg;
                sec_next   = rsb_pkg::BASIS_CYAN;
                if (green_reg <= blue_reg)
                begin
                    w_mid_next = green_reg - red_reg;
                    w_top_next = blue_reg - green_reg;
                    pri_next   = rsb_pkg::BASIS_BLUE;
                end
                else
                begin
                    w_mid_next = blue_reg - red_reg;
                    w_top_next = green_reg - blue_reg;
                    pri_next   = rsb_pkg::BASIS_GREEN;
                end
            end
            else if (green_reg <= red_reg && green_reg <= blue_reg)
            begin
                w_min_next = green_reg;
                sec_next   = rsb_pkg::BASIS_MAGENTA;
                if (red_reg <= blue_reg)
                begin
                    w_mid_next = red_reg - green_reg;
                    w_top_next = blue_reg - red_reg;
                    pri_next   = rsb_pkg::BASIS_BLUE;
                end
                else
                begin
                    w_mid_next = blue_reg - green_reg;
                    w_top_next = red_reg - blue_reg;
                    pri_next   = rsb_pkg::BASIS_RED;
                end
            end
            else
            begin
                w_min_next = blue_reg;
                sec_next   = rsb_pkg::BASIS_YELLOW;
                if (red_reg <= green_reg)
                begin
                    w_mid_next = red_reg - blue_reg;
                    w_top_next = green_reg - red_reg;
                    pri_next   = rsb_pkg::BASIS_GREEN;
                end
                else
                begin
                    w_mid_next = green_reg - blue_reg;
                    w_top_next = red_reg - green_reg;
                    pri_next   = rsb_pkg::BASIS_RED;
                end
            end
        end

        if (state_reg == rsb_pkg::SEQ_ISSUE)
        begin
            case (term_reg)
                rsb_pkg::TERM_WHITE:     term_next = rsb_pkg::TERM_SECONDARY;
                rsb_pkg::TERM_SECONDARY: term_next = rsb_pkg::TERM_PRIMARY;
                default:                 term_next = rsb_pkg::TERM_WHITE;
            endcase
        end

        if (emit)
        begin
            res_valid_next               = 1'b1;
            res_data_next.out_slot       = 2'(sample_reg);
            res_data_next.spectrum_value = stat.value;
            res_data_next.last_sample    = last_sample;
            sample_next                  = sample_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rsb_pkg::SEQ_IDLE;
            res_valid_reg <= 1'b0;
            term_reg      <= rsb_pkg::TERM_WHITE;
            sample_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            term_reg      <= term_next;
            sample_reg    <= sample_next;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg      <= red_next;
        green_reg    <= green_next;
        blue_reg     <= blue_next;
        w_min_reg    <= w_min_next;
        w_mid_reg    <= w_mid_next;
        w_top_reg    <= w_top_next;
        sec_reg      <= sec_next;
        pri_reg      <= pri_next;
        res_data_reg <= res_data_next;
    end

endmodule

/* hw/rtl/rgb_to_spectrum_basis_blend.sv */
// top level of the rgb to spectrum basis blend
//
// requests come in on item, results leave on result; both are valid/ready
// channels, a transfer happens on a clock edge with valid and ready high.
// a load request (operation 0) writes one basis entry at basis_select and
// sample_slot; a bad basis or a slot at or beyond SAMPLES is dropped. a load
// gives no result.
// a convert request (operation 1) gives SAMPLES results, slot 0 first, the
// last one flagged by last_sample. a sort state orders the channels, then each
// sample takes three table reads and three passes through the single
// 16 x 16 multiplier. a sample starts only once the one before sits in the
// output register; the single multiplier and the single table read port
// set the pace of a conversion.
// item.ready stays low while a conversion runs; it rises again once the
// last sample sits in the output register, even if that result waits.
// a stalled receiver holds the result register; the sequencer then waits
// with the finished sum and does not start the next sample.
// reset clears control state only: the basis table is undefined until
// loaded, and a convert must only read loaded entries.
module rgb_to_spectrum_basis_blend #(
    parameter int unsigned SAMPLES = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    rsb_item_if.sink      item,
    rsb_result_if.source  result
);

    localparam int unsigned DEPTH = rsb_pkg::BASIS_COUNT * SAMPLES;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned SLOT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

    // table ports
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic                         rd_en;
    logic [ADDR_W-1:0]            rd_addr;
    logic [rsb_pkg::VALUE_W-1:0]  rd_data;

    // sequencer to shared multiply-accumulate unit
    rsb_pkg::mac_ctl_t            mac_ctl;
    rsb_pkg::mac_stat_t           mac_stat;

    rsb_table #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item.data.entry_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rsb_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .rd_data (rd_data),
        .stat    (mac_stat)
    );

    rsb_seq #(
        .SAMPLES (SAMPLES),
        .ADDR_W  (ADDR_W),
        .SLOT_W  (SLOT_W)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .result  (result),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .ctl     (mac_ctl),
        .stat    (mac_stat)
    );

endmodule

/* hw/rtl/rsb_checker.sv */
// port-level checks for the rgb to spectrum basis blend, with bind
module rsb_checker (
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_ready,
    input logic item_operation,
    input logic result_valid,
    input logic result_ready,
    input logic [1:0] result_slot,
    input logic [rsb_pkg::VALUE_W-1:0] result_value,
    input logic result_last
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_slot) && $stable(result_value)
            && $stable(result_last))
    else $error("stalled result changed");

    // a convert request makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_operation == rsb_pkg::OP_CONVERT |=> !item_ready)
    else $error("ready after convert request");

    // a load request never makes a result
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_operation == rsb_pkg::OP_LOAD && !result_valid
            |=> !result_valid)
    else $error("result after load request");

    // while a conversion is still giving samples no request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_last |-> !item_ready)
    else $error("ready in the middle of a conversion");

endmodule

bind rgb_to_spectrum_basis_blend rsb_checker u_rsb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .item_operation (item.data.operation),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_slot    (result.data.out_slot),
    .result_value   (result.data.spectrum_value),
    .result_last    (result.data.last_sample)
);

/* tb/sv/testbench.sv */
// self-checking testbench for the rgb to spectrum basis blend
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned SAMPLES = 4;
    localparam int RANDOM_REQUESTS = 150;
    // leave room for stray results after the queue has drained
    localparam int DRAIN_CYCLES = 64;
    // a generous bound for the ~200 requests of the run
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PERCENT = 16;

    // one row of the directed stimulus; level is the typed-in value of every
    // sample, used only where typed is set
    typedef struct {
        rsb_pkg::item_t req;
        bit             typed;
        logic [15:0]    level;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;

    rsb_item_if   request_bus ();
    rsb_result_if result_bus ();

    rgb_to_spectrum_basis_blend #(
        .SAMPLES (SAMPLES)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (request_bus),
        .result (result_bus)
    );

    // private copy of the basis table, indexed by basis then wavelength sample
    logic [rsb_pkg::VALUE_W-1:0] basis_copy [rsb_pkg::BASIS_COUNT][SAMPLES];
    // spectrum samples still owed by the block, oldest first
    rsb_pkg::result_t spectrum_queue [$];
    int errors = 0;
    int cycles = 0;
    // both sides stop idling while this is set
    bit calm = 1'b0;

    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // expected samples for one accepted request; a load only updates the copy
    function automatic void blend_spectrum(input rsb_pkg::item_t req);
        logic [rsb_pkg::VALUE_W-1:0] r, g, b, w_min, w_mid, w_top;
        logic [2:0]                  sec, pri;
        logic [63:0]                 acc, level;
        rsb_pkg::result_t            sample;

        if (req.operation == rsb_pkg::OP_LOAD)
        begin
            // bad basis select or slot past the table is dropped
            if (req.basis_select < rsb_pkg::BASIS_COUNT && req.sample_slot < SAMPLES)
                basis_copy[req.basis_select][req.sample_slot] = req.entry_value;
            return;
        end
        r = req.red;
        g = req.green;
        b = req.blue;
        // smallest channel picks the secondary; ties go to red, then green
        if (r <= g && r <= b)
        begin
            w_min = r;
            sec = rsb_pkg::BASIS_CYAN;
            if (g <= b)
            begin
                w_mid = g - r;
                w_top = b - g;
                pri = rsb_pkg::BASIS_BLUE;
            end
            else
            begin
                w_mid = b - r;
                w_top = g - b;
                pri = rsb_pkg::BASIS_GREEN;
            end
        end
        else if (g <= r && g <= b)
        begin
            w_min = g;
            sec = rsb_pkg::BASIS_MAGENTA;
            if (r <= b)
            begin
                w_mid = r - g;
                w_top = b - r;
                pri = rsb_pkg::BASIS_BLUE;
            end
            else
            begin
                w_mid = b - g;
                w_top = r - b;
                pri = rsb_pkg::BASIS_RED;
            end
        end
        else
        begin
            w_min = b;
            sec = rsb_pkg::BASIS_YELLOW;
            if (r <= g)
            begin
                w_mid = r - b;
                w_top = g - r;
                pri = rsb_pkg::BASIS_GREEN;
            end
            else
            begin
                w_mid = g - b;
                w_top = r - g;
                pri = rsb_pkg::BASIS_RED;
            end
        end
        for (int j = 0; j < SAMPLES; j++)
        begin
            // q4.12 weights times q1.15 basis, summed exactly, rounded to q4.12
            acc = 64'(w_min) * 64'(basis_copy[rsb_pkg::BASIS_WHITE][j])
                + 64'(w_mid) * 64'(basis_copy[sec][j])
                + 64'(w_top) * 64'(basis_copy[pri][j]);
            level = (acc + 64'(1 << (rsb_pkg::FRAC_SHIFT - 1))) >> rsb_pkg::FRAC_SHIFT;
            if (level > 64'hFFFF)
                level = 64'hFFFF;
            sample.out_slot = 2'(j);
            sample.spectrum_value = level[15:0];
            sample.last_sample = (j == SAMPLES - 1);
            spectrum_queue.push_back(sample);
        end
    endfunction

    // load request; the channel fields carry noise
    function automatic rsb_pkg::item_t load_req(input logic [2:0] sel,
                                                input logic [1:0] slot,
                                                input logic [15:0] value);
        rsb_pkg::item_t req;

        req.operation = rsb_pkg::OP_LOAD;
        req.basis_select = sel;
        req.sample_slot = slot;
        req.entry_value = value;
        req.red = 16'($urandom);
        req.green = 16'($urandom);
        req.blue = 16'($urandom);
        return req;
    endfunction

    // convert request; the load fields carry noise
    function automatic rsb_pkg::item_t convert_req(input logic [15:0] r,
                                                   input logic [15:0] g,
                                                   input logic [15:0] b);
        rsb_pkg::item_t req;

        req.operation = rsb_pkg::OP_CONVERT;
        req.basis_select = 3'($urandom);
        req.sample_slot = 2'($urandom);
        req.entry_value = 16'($urandom);
        req.red = r;
        req.green = g;
        req.blue = b;
        return req;
    endfunction

    // offer one request, with random idle cycles ahead of it, and wait for
    // the handshake; expectations are queued at the accepting edge
    task automatic send_request(input rsb_pkg::item_t req, input bit typed = 1'b0,
                                input logic [15:0] level = '0);
        rsb_pkg::result_t sample;

        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            request_bus.valid <= 1'b0;
            @(posedge clk);
        end
        request_bus.valid <= 1'b1;
        request_bus.data <= req;
        // values read right after the edge are the ones the edge saw
        do
            @(posedge clk);
        while (!request_bus.ready);
        if (typed)
        begin
            for (int j = 0; j < SAMPLES; j++)
            begin
                sample.out_slot = 2'(j);
                sample.spectrum_value = level;
                sample.last_sample = (j == SAMPLES - 1);
                spectrum_queue.push_back(sample);
            end
        end
        else
            blend_spectrum(req);
    endtask

    // result side: check every accepted sample, then pick the next ready
    always @(posedge clk)
    begin : result_check
        rsb_pkg::result_t got, wanted;

        if (result_bus.valid && result_bus.ready)
        begin
            got = result_bus.data;
            if (spectrum_queue.size() == 0)
            begin
                $error("spectrum sample with none pending: slot %0d value %h",
                       got.out_slot, got.spectrum_value);
                errors++;
            end
            else
            begin
                wanted = spectrum_queue.pop_front();
                if (got.out_slot !== wanted.out_slot)
                begin
                    $error("out_slot: expected %0d, actual %0d",
                           wanted.out_slot, got.out_slot);
                    errors++;
                end
                if (got.spectrum_value !== wanted.spectrum_value)
                begin
                    $error("spectrum_value: expected %h, actual %h",
                           wanted.spectrum_value, got.spectrum_value);
                    errors++;
                end
                if (got.last_sample !== wanted.last_sample)
                begin
                    $error("last_sample: expected %0d, actual %0d",
                           wanted.last_sample, got.last_sample);
                    errors++;
                end
            end
        end
        result_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    initial
    begin
        directed_row_t  directed_plan [$];
        rsb_pkg::item_t req;
        logic [15:0]    r, g, b;
        int             mode;

        request_bus.valid = 1'b0;
        request_bus.data = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the table is undefined after reset: fill every entry before any convert
        for (int sel = 0; sel < rsb_pkg::BASIS_COUNT; sel++)
            for (int slot = 0; slot < SAMPLES; slot++)
                send_request(load_req(3'(sel), 2'(slot), 16'($urandom)));

        // white at exactly one, so grey inputs come straight through
        for (int slot = 0; slot < SAMPLES; slot++)
            directed_plan.push_back('{load_req(rsb_pkg::BASIS_WHITE, 2'(slot), 16'h8000),
                                      1'b0, '0});
        directed_plan.push_back('{convert_req(16'h0000, 16'h0000, 16'h0000), 1'b1, 16'h0000});
        directed_plan.push_back('{convert_req(16'h1000, 16'h1000, 16'h1000), 1'b1, 16'h1000});
        directed_plan.push_back('{convert_req(16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1, 16'hFFFF});
        // basis select 7 must not land anywhere in the table
        directed_plan.push_back('{load_req(3'd7, 2'd0, 16'hFFFF), 1'b0, '0});
        // every ordering of the channels, then the tie-breaks
        directed_plan.push_back('{convert_req(16'h0100, 16'h0800, 16'h2000), 1'b0, '0});
        directed_plan.push_back('{convert_req(16'h0100, 16'h2000, 16'h0800), 1'b0, '0});
        directed_plan.push_back('{convert_req(16'h0800, 16'h0100, 16'h2000), 1'b0, '0});
        directed_plan.push_back('{convert_req(16'h2000, 16'h0100, 16'h0800), 1'b0, '0});
        directed_plan.push_back('{convert_req(16'h0800, 16'h2000, 16'h0100), 1'b0, '0});
        directed_plan.push_back('{convert_req(16'h2000, 16'h0800, 16'h0100), 1'b0, '0});
        directed_plan.push_back('{convert_req(16'h0400, 16'h0400, 16'h0400), 1'b0, '0});
        directed_plan.push_back('{convert_req(16'h0400, 16'h0400, 16'hFFFF), 1'b0, '0});
        directed_plan.push_back('{convert_req(16'hFFFF, 16'h0000, 16'h0000), 1'b0, '0});
        // white at its top value: grey input at full scale saturates
        for (int slot = 0; slot < SAMPLES; slot++)
            directed_plan.push_back('{load_req(rsb_pkg::BASIS_WHITE, 2'(slot), 16'hFFFF),
                                      1'b0, '0});
        directed_plan.push_back('{convert_req(16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1, 16'hFFFF});

        foreach (directed_plan[i])
            send_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].level);

        // random mix: loads rewrite the table as it goes, converts read it
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            calm = (n >= 70 && n < 120);
            if ($urandom_range(0, 99) < 30)
                req = load_req(3'($urandom_range(0, 7)), 2'($urandom), 16'($urandom));
            else
            begin
                r = 16'($urandom);
                g = 16'($urandom);
                b = 16'($urandom);
                mode = $urandom_range(0, 3);
                case (mode)
                    1:
                    begin
                        // small channels, mostly unsaturated
                        r = r >> 4;
                        g = g >> 4;
                        b = b >> 4;
                    end
                    2:
                    begin
                        // two channels tied
                        case ($urandom_range(0, 2))
                            0: g = r;
                            1: b = g;
                            default: b = r;
                        endcase
                    end
                    3:
                    begin
                        // each channel at zero or full scale
                        r = {16{r[0]}};
                        g = {16{g[0]}};
                        b = {16{b[0]}};
                    end
                    default: ;
                endcase
                req = convert_req(r, g, b);
            end
            send_request(req);
        end
        calm = 1'b0;
        request_bus.valid <= 1'b0;

        // drain, then watch a while longer for stray samples
        while (spectrum_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
